FILE: sv/binary_min_heap_queue_top_defines.svh
// Assertion macros for the binary min-heap queue RTL.
// Used by the controller and datapath; expects clk_i and rst_ni in scope.
`ifndef BINARY_MIN_HEAP_QUEUE_TOP_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BMHQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BMHQ_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define BMHQ_ASSERT(lbl, prop, msg)
`define BMHQ_NEVER(lbl, cond, msg)
`endif
`endif

FILE: sv/bmhq_pkg.sv
// Shared types and constants of the binary min-heap queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bmhq_pkg;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned PAY_W  = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCC_W  = 11;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic start;
    logic pop_rd;
    logic pop_ld;
    logic up_rd;
    logic up_cmp;
    logic dn_rd;
    logic dn_cmp;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic last_one;
    logic at_root;
    logic up_swap;
    logic dn_stop;
  } dp_sts_t;
endpackage
`default_nettype wire

FILE: sv/bmhq_if.sv
// Handshake channels of the binary min-heap queue: command in, result out.
// Depends on bmhq_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface bmhq_in_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [bmhq_pkg::KEY_W-1:0] item_key;
  logic [bmhq_pkg::PAY_W-1:0] item_payload;
  modport source (output valid, command, item_key, item_payload, input ready);
  modport sink (input valid, command, item_key, item_payload, output ready);
endinterface

interface bmhq_out_if;
  logic                       valid;
  logic                       ready;
  logic [bmhq_pkg::STAT_W-1:0] status;
  logic [bmhq_pkg::KEY_W-1:0]  out_key;
  logic [bmhq_pkg::PAY_W-1:0]  out_payload;
  logic [bmhq_pkg::OCC_W-1:0]  occupancy;
  modport source (output valid, status, out_key, out_payload, occupancy, input ready);
  modport sink (input valid, status, out_key, out_payload, occupancy, output ready);
endinterface
`default_nettype wire

FILE: sv/bmhq_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bmhq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q, rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;
endmodule
`default_nettype wire

FILE: sv/bmhq_ctrl.sv
// Sequencer of the binary min-heap queue: insert sift-up, pop sift-down, result.
// Depends on bmhq_pkg and binary_min_heap_queue_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "binary_min_heap_queue_top_defines.svh"
module bmhq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_command_i,
  output logic                   in_ready_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  input  wire bmhq_pkg::dp_sts_t sts_i,
  output bmhq_pkg::dp_cmd_t      cmd_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_POP_RD, S_POP_LD, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP, S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o        = '0;
    state_d      = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.start = 1'b1;
          if (in_command_i == bmhq_pkg::CMD_INSERT) begin
            state_d = sts_i.full ? S_RESP : S_UP_RD;
          end else begin
            state_d = sts_i.empty ? S_RESP : S_POP_RD;
          end
        end
      end
      S_POP_RD: begin
        cmd_o.pop_rd = 1'b1;
        state_d      = S_POP_LD;
      end
      S_POP_LD: begin
        cmd_o.pop_ld = 1'b1;
        state_d      = sts_i.last_one ? S_RESP : S_DN_RD;
      end
      S_UP_RD: begin
        cmd_o.up_rd = 1'b1;
        state_d     = sts_i.at_root ? S_RESP : S_UP_CMP;
      end
      S_UP_CMP: begin
        cmd_o.up_cmp = 1'b1;
        state_d      = sts_i.up_swap ? S_UP_RD : S_RESP;
      end
      S_DN_RD: begin
        cmd_o.dn_rd = 1'b1;
        state_d     = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd_o.dn_cmp = 1'b1;
        state_d      = sts_i.dn_stop ? S_RESP : S_DN_RD;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `BMHQ_NEVER(a_no_overwrite, cmd_o.finish && out_valid_q && !out_ready_i, "result word overwritten")
  `BMHQ_ASSERT(a_empty_pop, accept && in_command_i == bmhq_pkg::CMD_POP && sts_i.empty |=> state_q == S_RESP, "empty pop not answered at once")
endmodule
`default_nettype wire

FILE: sv/bmhq_dp.sv
// Datapath of the binary min-heap queue: heap RAM, count, hole position, result.
// Depends on bmhq_pkg, bmhq_ram and binary_min_heap_queue_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "binary_min_heap_queue_top_defines.svh"
module bmhq_dp #(
  parameter int unsigned CAPACITY = 1024,
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire bmhq_pkg::dp_cmd_t           cmd_i,
  output bmhq_pkg::dp_sts_t                sts_o,
  input  wire logic                        in_command_i,
  input  wire logic [bmhq_pkg::KEY_W-1:0]  in_key_i,
  input  wire logic [bmhq_pkg::PAY_W-1:0]  in_payload_i,
  output logic      [bmhq_pkg::STAT_W-1:0] status_o,
  output logic      [bmhq_pkg::KEY_W-1:0]  out_key_o,
  output logic      [bmhq_pkg::PAY_W-1:0]  out_payload_o,
  output logic      [bmhq_pkg::OCC_W-1:0]  occupancy_o
);
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [AW-1:0]               pos_q, pos_d;
  bmhq_pkg::entry_t            mv_q, mv_d;
  bmhq_pkg::entry_t            top_q, top_d;
  logic [bmhq_pkg::STAT_W-1:0] stat_q, stat_d;
  logic [bmhq_pkg::STAT_W-1:0] res_stat_q;
  bmhq_pkg::entry_t            res_top_q;
  logic [bmhq_pkg::OCC_W-1:0]  res_occ_q;

  logic                         we;
  logic [AW-1:0]                waddr, raddr_a, raddr_b;
  bmhq_pkg::entry_t             wdata;
  logic [bmhq_pkg::ENTRY_W-1:0] rdata_a, rdata_b;
  bmhq_pkg::entry_t             rd_a, rd_b;

  logic [AW-1:0]   parent;
  logic [AW+1:0]   lc, rc, cnt_x;
  logic            use_l, use_r;
  logic [bmhq_pkg::KEY_W-1:0] tkey;

  assign rd_a   = bmhq_pkg::entry_t'(rdata_a);
  assign rd_b   = bmhq_pkg::entry_t'(rdata_b);
  assign parent = AW'((pos_q - AW'(1)) >> 1);
  assign lc     = (AW + 2)'({pos_q, 1'b1});
  assign rc     = lc + (AW + 2)'(1);
  assign cnt_x  = (AW + 2)'(cnt_q);
  assign use_l  = (lc < cnt_x) && (mv_q.key >= rd_a.key);
  assign tkey   = use_l ? rd_a.key : mv_q.key;
  assign use_r  = (rc < cnt_x) && (tkey >= rd_b.key);

  assign sts_o.full     = (cnt_q >= CW'(CAPACITY));
  assign sts_o.empty    = (cnt_q == '0);
  assign sts_o.last_one = (cnt_q == CW'(1));
  assign sts_o.at_root  = (pos_q == '0);
  assign sts_o.up_swap  = (mv_q.key <= rd_a.key);
  assign sts_o.dn_stop  = !use_l && !use_r;

  always_comb begin
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    mv_d    = mv_q;
    top_d   = top_q;
    stat_d  = stat_q;
    we      = 1'b0;
    waddr   = pos_q;
    wdata   = mv_q;
    raddr_a = '0;
    raddr_b = '0;
    if (cmd_i.start) begin
      mv_d   = '{key: in_key_i, payload: in_payload_i};
      top_d  = '0;
      stat_d = bmhq_pkg::ST_DONE;
      if (in_command_i == bmhq_pkg::CMD_INSERT) begin
        if (sts_o.full) begin
          stat_d = bmhq_pkg::ST_FULL;
        end else begin
          pos_d = AW'(cnt_q);
          cnt_d = cnt_q + CW'(1);
        end
      end else if (sts_o.empty) begin
        stat_d = bmhq_pkg::ST_EMPTY;
      end
    end
    if (cmd_i.pop_rd) begin
      raddr_a = '0;
      raddr_b = AW'(cnt_q - CW'(1));
    end
    if (cmd_i.pop_ld) begin
      top_d = rd_a;
      mv_d  = rd_b;
      cnt_d = cnt_q - CW'(1);
      pos_d = '0;
    end
    if (cmd_i.up_rd) begin
      raddr_a = parent;
      if (sts_o.at_root) begin
        we = 1'b1;
      end
    end
    if (cmd_i.up_cmp) begin
      we = 1'b1;
      if (sts_o.up_swap) begin
        wdata = rd_a;
        pos_d = parent;
      end
    end
    if (cmd_i.dn_rd) begin
      raddr_a = AW'(lc);
      raddr_b = AW'(rc);
    end
    if (cmd_i.dn_cmp) begin
      we = 1'b1;
      if (use_r) begin
        wdata = rd_b;
        pos_d = AW'(rc);
      end else if (use_l) begin
        wdata = rd_a;
        pos_d = AW'(lc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    mv_q   <= mv_d;
    top_q  <= top_d;
    stat_q <= stat_d;
    if (cmd_i.finish) begin
      res_stat_q <= stat_q;
      res_top_q  <= top_q;
      res_occ_q  <= bmhq_pkg::OCC_W'(cnt_q);
    end
  end

  bmhq_ram #(
    .WIDTH(bmhq_pkg::ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_heap_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  assign status_o      = res_stat_q;
  assign out_key_o     = res_top_q.key;
  assign out_payload_o = res_top_q.payload;
  assign occupancy_o   = res_occ_q;

  `BMHQ_NEVER(a_cnt_range, cnt_q > CW'(CAPACITY), "entry count above capacity")
  `BMHQ_ASSERT(a_dn_in_heap, cmd_i.dn_cmp |-> CW'(pos_q) < cnt_q, "sift-down hole outside heap")
endmodule
`default_nettype wire

FILE: sv/binary_min_heap_queue_top.sv
// Binary min-heap priority queue, up to CAPACITY key/payload entries in one RAM.
// Insert sifts the new entry up, one parent compare per level climbed; pop takes the root,
// moves the last entry there and sifts it down; a dropped insert or an empty pop goes
// straight to the result word. A new word is taken only once the last result is in the
// output register; the sequencer waits in its result state until that register is free.
// Asynchronous active-low reset empties the heap; RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module binary_min_heap_queue_top #(
  parameter int unsigned CAPACITY = 1024
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bmhq_in_if.sink    in_i,
  bmhq_out_if.source out_o
);
  bmhq_pkg::dp_cmd_t cmd;
  bmhq_pkg::dp_sts_t sts;

  bmhq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_command_i(in_i.command),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bmhq_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_command_i (in_i.command),
    .in_key_i     (in_i.item_key),
    .in_payload_i (in_i.item_payload),
    .status_o     (out_o.status),
    .out_key_o    (out_o.out_key),
    .out_payload_o(out_o.out_payload),
    .occupancy_o  (out_o.occupancy)
  );
endmodule
`default_nettype wire

FILE: tb/sv/binary_min_heap_queue_top_tb.sv
// Self-checking testbench of the binary min-heap priority queue top level.
// Drives insert/pop words through bmhq_in_if and checks every result word against a
// behavioral heap predictor; depends on bmhq_pkg, bmhq_if and binary_min_heap_queue_top.
`timescale 1ns / 1ps
module binary_min_heap_queue_top_tb;

  localparam int unsigned CAP = 1024;

  typedef struct packed {
    logic [bmhq_pkg::STAT_W-1:0] status;
    logic [bmhq_pkg::KEY_W-1:0]  key;
    logic [bmhq_pkg::PAY_W-1:0]  payload;
    logic [bmhq_pkg::OCC_W-1:0]  occ;
  } result_t;

  typedef struct {
    logic                        command;
    logic [bmhq_pkg::KEY_W-1:0]  key;
    logic [bmhq_pkg::PAY_W-1:0]  payload;
    bit                          has_exp;
    result_t                     exp_res;
  } stim_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  bmhq_in_if  in_ch ();
  bmhq_out_if out_ch ();

  binary_min_heap_queue_top #(.CAPACITY(CAP)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  logic [bmhq_pkg::KEY_W-1:0] heap_key[CAP];
  logic [bmhq_pkg::PAY_W-1:0] heap_pay[CAP];
  int unsigned                heap_n;

  result_t     pending_results[$];
  stim_t       stim_q[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned empties_seen;
  int unsigned fulls_seen;
  bit          hold_off;
  bit          no_idle;

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [bmhq_pkg::KEY_W-1:0] k;
    logic [bmhq_pkg::PAY_W-1:0] p;
    k = heap_key[a];
    p = heap_pay[a];
    heap_key[a] = heap_key[b];
    heap_pay[a] = heap_pay[b];
    heap_key[b] = k;
    heap_pay[b] = p;
  endfunction

  function automatic result_t predict_heap(logic cmd, logic [bmhq_pkg::KEY_W-1:0] key,
                                           logic [bmhq_pkg::PAY_W-1:0] pay);
    result_t     r;
    int unsigned pos;
    int unsigned up;
    int unsigned pick;
    r = '0;
    r.status = bmhq_pkg::ST_DONE;
    if (cmd == bmhq_pkg::CMD_INSERT) begin
      if (heap_n >= CAP) begin
        r.status = bmhq_pkg::ST_FULL;
      end else begin
        pos = heap_n;
        heap_key[pos] = key;
        heap_pay[pos] = pay;
        heap_n++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_key[pos] > heap_key[up]) break;
          swap_slots(pos, up);
          pos = up;
        end
      end
    end else begin
      if (heap_n == 0) begin
        r.status = bmhq_pkg::ST_EMPTY;
      end else begin
        r.key = heap_key[0];
        r.payload = heap_pay[0];
        heap_n--;
        heap_key[0] = heap_key[heap_n];
        heap_pay[0] = heap_pay[heap_n];
        pos = 0;
        forever begin
          pick = pos;
          if (2*pos+1 < heap_n && heap_key[pick] >= heap_key[2*pos+1]) pick = 2*pos+1;
          if (2*pos+2 < heap_n && heap_key[pick] >= heap_key[2*pos+2]) pick = 2*pos+2;
          if (pick == pos) break;
          swap_slots(pos, pick);
          pos = pick;
        end
      end
    end
    r.occ = heap_n[bmhq_pkg::OCC_W-1:0];
    return r;
  endfunction

  function automatic result_t fixed_result(logic [bmhq_pkg::STAT_W-1:0] st,
                                           logic [bmhq_pkg::KEY_W-1:0] k,
                                           logic [bmhq_pkg::PAY_W-1:0] p, int unsigned occ);
    result_t r;
    r.status = st;
    r.key = k;
    r.payload = p;
    r.occ = occ[bmhq_pkg::OCC_W-1:0];
    return r;
  endfunction

  task automatic add_row(logic cmd, logic [bmhq_pkg::KEY_W-1:0] k,
                         logic [bmhq_pkg::PAY_W-1:0] p,
                         bit has_exp = 1'b0, result_t er = '0);
    stim_t s;
    s.command = cmd;
    s.key = k;
    s.payload = p;
    s.has_exp = has_exp;
    s.exp_res = er;
    stim_q.push_back(s);
  endtask

  task automatic drive_word(stim_t s);
    result_t r;
    in_ch.valid        <= 1'b1;
    in_ch.command      <= s.command;
    in_ch.item_key     <= s.key;
    in_ch.item_payload <= s.payload;
    do @(posedge clk_i); while (!in_ch.ready);
    r = predict_heap(s.command, s.key, s.payload);
    if (s.has_exp && r !== s.exp_res) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row disagrees with predictor: row %h predictor %h", s.exp_res, r);
    end
    pending_results.push_back(s.has_exp ? s.exp_res : r);
  endtask

  task automatic send_all(int unsigned idle_pct);
    stim_t s;
    while (stim_q.size() > 0) begin
      s = stim_q.pop_front();
      drive_word(s);
      if (!no_idle && $urandom_range(99) < idle_pct) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() > 0) @(posedge clk_i);
  endtask

  task automatic random_phase(int unsigned n, int unsigned pop_pct, bit narrow_keys);
    logic [bmhq_pkg::KEY_W-1:0] k;
    for (int unsigned i = 0; i < n; i++) begin
      k = narrow_keys ? $urandom_range(15) : $urandom();
      if ($urandom_range(9) == 0) k = ($urandom_range(1) != 0) ? '1 : '0;
      add_row(($urandom_range(99) < pop_pct) ? bmhq_pkg::CMD_POP : bmhq_pkg::CMD_INSERT,
              k, $urandom());
    end
  endtask

  // result side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && (no_idle || $urandom_range(99) >= 11);
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.status = out_ch.status;
      got.key = out_ch.out_key;
      got.payload = out_ch.out_payload;
      got.occ = out_ch.occupancy;
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
      end else begin
        want = pending_results.pop_front();
        if (want.status == bmhq_pkg::ST_EMPTY) empties_seen++;
        if (want.status == bmhq_pkg::ST_FULL) fulls_seen++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status %0d/%0d key %h/%h payload %h/%h occupancy %0d/%0d",
                     want.status, got.status, want.key, got.key, want.payload,
                     got.payload, want.occ, got.occ);
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("binary_min_heap_queue_top regression: fail");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = bmhq_pkg::CMD_INSERT;
    in_ch.item_key = '0;
    in_ch.item_payload = '0;
    hold_off = 1'b0;
    no_idle = 1'b0;
    heap_n = 0;
    mismatches = 0;
    results_seen = 0;
    empties_seen = 0;
    fulls_seen = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    add_row(bmhq_pkg::CMD_POP, '1, '1, 1'b1, fixed_result(bmhq_pkg::ST_EMPTY, '0, '0, 0));
    add_row(bmhq_pkg::CMD_INSERT, '1, '1, 1'b1, fixed_result(bmhq_pkg::ST_DONE, '0, '0, 1));
    add_row(bmhq_pkg::CMD_INSERT, '0, 32'h0, 1'b1,
            fixed_result(bmhq_pkg::ST_DONE, '0, '0, 2));
    add_row(bmhq_pkg::CMD_POP, 32'h1234, 32'h5678, 1'b1,
            fixed_result(bmhq_pkg::ST_DONE, '0, '0, 1));
    add_row(bmhq_pkg::CMD_POP, '0, '0, 1'b1, fixed_result(bmhq_pkg::ST_DONE, '1, '1, 0));
    add_row(bmhq_pkg::CMD_POP, '0, '0, 1'b1, fixed_result(bmhq_pkg::ST_EMPTY, '0, '0, 0));
    add_row(bmhq_pkg::CMD_INSERT, 32'h5, 32'hAAAA_AAAA);
    add_row(bmhq_pkg::CMD_INSERT, 32'h5, 32'h5555_5555);
    add_row(bmhq_pkg::CMD_INSERT, 32'h5, 32'h0000_0001);
    add_row(bmhq_pkg::CMD_INSERT, 32'h3, 32'h8000_0000);
    add_row(bmhq_pkg::CMD_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
    add_row(bmhq_pkg::CMD_INSERT, 32'h7FFF_FFFF, 32'hFFFF_0000);
    for (int i = 0; i < 7; i++) add_row(bmhq_pkg::CMD_POP, $urandom(), $urandom());
    send_all(11);
    wait_drained();

    // fill to capacity and overflow, receiver stalls long in the middle; then a narrow-key mix and pops
    no_idle = 1'b1;
    for (int unsigned i = 0; i < CAP; i++)
      add_row(bmhq_pkg::CMD_INSERT, $urandom_range(63), i);
    add_row(bmhq_pkg::CMD_INSERT, '0, '0, 1'b1, fixed_result(bmhq_pkg::ST_FULL, '0, '0, CAP));
    add_row(bmhq_pkg::CMD_INSERT, '1, '1, 1'b1, fixed_result(bmhq_pkg::ST_FULL, '0, '0, CAP));
    fork
      send_all(0);
      begin
        repeat (200) @(posedge clk_i);
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    wait_drained();
    no_idle = 1'b0;
    random_phase(40, 50, 1'b1);
    for (int unsigned i = 0; i < 20; i++) add_row(bmhq_pkg::CMD_POP, $urandom(), $urandom());
    send_all(11);
    wait_drained();

    // random mix on a deep heap, then a pop-heavy stretch
    random_phase(300, 70, 1'b0);
    send_all(11);
    random_phase(300, 90, 1'b1);
    send_all(11);
    wait_drained();
    repeat (100) @(posedge clk_i);

    $display("covered %0d result words: empty-heap pops %0d, dropped inserts %0d",
             results_seen, empties_seen, fulls_seen);
    $display("heap filled to %0d entries with a long result-side stall", CAP);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("binary_min_heap_queue_top regression: pass");
    end else begin
      $display("binary_min_heap_queue_top regression: fail");
    end
    $finish;
  end
endmodule
